// ===== src/owss_pkg.sv =====
// shared types and constants for the 1-wire sensor scan sequencer
package owss_pkg;

	localparam int MAX_DEVICES_DEF = 8;
	localparam logic [7:0] FAMILY_RESET = 8'd40;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 88;
	localparam int ROM_W      = 64;
	localparam int INDEX_W    = 3;
	localparam int LISTED_W   = 4;

	typedef enum logic [2:0] {
		ACT_NONE         = 3'd0,
		ACT_SEARCH_FIRST = 3'd1,
		ACT_SEARCH_NEXT  = 3'd2,
		ACT_CONVERT      = 3'd3,
		ACT_READ         = 3'd4,
		ACT_REPORT       = 3'd5
	} act_t;

	typedef enum logic [9:0] {
		PH_IDLE          = 10'b00_0000_0001,
		PH_LIST_FIRST    = 10'b00_0000_0010,
		PH_LIST_NEXT     = 10'b00_0000_0100,
		PH_LIST_CHECK    = 10'b00_0000_1000,
		PH_CONVERT       = 10'b00_0001_0000,
		PH_CONVERT_CHECK = 10'b00_0010_0000,
		PH_ENUM_START    = 10'b00_0100_0000,
		PH_ENUM          = 10'b00_1000_0000,
		PH_READ          = 10'b01_0000_0000,
		PH_EXTRACT       = 10'b10_0000_0000
	} phase_t;

endpackage

// ===== src/onewire_sensor_scan_sequencer.sv =====
// 1-wire sensor scan sequencer top level
// each result passes through the input register and then the result register
// throughput: one input transaction per cycle unless the output stalls, one result per input
// the device table ram is read at the next cursor value, so its data is ready for the next step
// reset clears phase to idle, cursor and device count to zero, family code to 40
// device table entries are not cleared by reset and are defined only once written
module onewire_sensor_scan_sequencer
	import owss_pkg::*;
#(
	parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// bus_failed, found_rom, scratch_low, scratch_high, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// last_device_found
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// device_index, device_rom, report_low, report_high, report_failed, devices_listed
	output logic [OUT_DATA_W-1:0] m_tdata,
	// action
	output logic [2:0]            m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data
);

	localparam int CW = $clog2(MAX_DEVICES + 1);
	localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_DEVICES);

	logic [7:0]       family_q;
	phase_t           phase_q, phase_d;
	logic [CW-1:0]    cursor_q, cursor_d, count_q, count_d, cursor_inc;

	logic             v_s1;
	logic             failed_s1, last_s1;
	logic [ROM_W-1:0] rom_s1;
	logic [7:0]       lo_s1, hi_s1;

	logic             v_s2;
	act_t             act_s2;
	logic [INDEX_W-1:0] idx_s2;
	logic [ROM_W-1:0] rom_s2;
	logic [7:0]       lo_s2, hi_s2;
	logic             fail_s2;
	logic [LISTED_W-1:0] listed_s2;

	logic             adv, step, wr_en;
	logic [ROM_W-1:0] rd_data;
	act_t             act_c;
	logic             idx_sel;
	logic [ROM_W-1:0] rom_c;
	logic [7:0]       lo_c, hi_c;
	logic             fail_c;
	logic [CW+INDEX_W-1:0]  cursor_ext;
	logic [CW+LISTED_W-1:0] count_ext;
	logic [INDEX_W-1:0]     idx_c;

	assign cfg_ready = 1'b1;
	assign adv       = !v_s2 || m_tready;
	assign s_tready  = !v_s1 || adv;
	assign step      = v_s1 && adv;

	assign cursor_inc = cursor_q + CW'(1);
	assign cursor_ext = {{INDEX_W{1'b0}}, cursor_q};
	assign count_ext  = {{LISTED_W{1'b0}}, count_d};
	assign idx_c      = idx_sel ? cursor_ext[INDEX_W-1:0] : '0;

	owss_ram #(
		.WIDTH (ROM_W),
		.DEPTH (MAX_DEVICES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cursor_q[AW-1:0]),
		.wr_data (rom_s1),
		.rd_addr (cursor_d[AW-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		phase_d  = phase_q;
		cursor_d = cursor_q;
		count_d  = count_q;
		wr_en    = 1'b0;
		act_c    = ACT_NONE;
		idx_sel  = 1'b0;
		rom_c    = '0;
		lo_c     = '0;
		hi_c     = '0;
		fail_c   = 1'b0;
		if (step) begin
			unique case (phase_q)
				PH_LIST_FIRST: begin
					cursor_d = '0;
					act_c    = ACT_SEARCH_FIRST;
					phase_d  = PH_LIST_CHECK;
				end
				PH_LIST_CHECK: begin
					phase_d = failed_s1 ? PH_IDLE : PH_LIST_NEXT;
				end
				PH_LIST_NEXT: begin
					wr_en    = 1'b1;
					cursor_d = cursor_inc;
					if (last_s1 || cursor_inc >= MAX_C) begin
						count_d = cursor_inc;
						phase_d = PH_CONVERT;
					end else begin
						act_c   = ACT_SEARCH_NEXT;
						phase_d = PH_LIST_CHECK;
					end
				end
				PH_CONVERT: begin
					act_c   = ACT_CONVERT;
					phase_d = PH_CONVERT_CHECK;
				end
				PH_CONVERT_CHECK: begin
					phase_d = failed_s1 ? PH_IDLE : PH_ENUM_START;
				end
				PH_ENUM_START: begin
					cursor_d = '0;
					phase_d  = PH_ENUM;
				end
				PH_ENUM: begin
					if (cursor_q >= count_q) begin
						phase_d = PH_IDLE;
					end else if (rd_data[7:0] == family_q) begin
						phase_d = PH_READ;
					end else begin
						cursor_d = cursor_inc;
					end
				end
				PH_READ: begin
					act_c   = ACT_READ;
					idx_sel = 1'b1;
					rom_c   = rd_data;
					phase_d = PH_EXTRACT;
				end
				PH_EXTRACT: begin
					act_c    = ACT_REPORT;
					idx_sel  = 1'b1;
					lo_c     = lo_s1;
					hi_c     = hi_s1;
					fail_c   = failed_s1;
					cursor_d = cursor_inc;
					phase_d  = PH_ENUM;
				end
				default: begin
					phase_d = PH_LIST_FIRST;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_q <= FAMILY_RESET;
			phase_q  <= PH_IDLE;
			cursor_q <= '0;
			count_q  <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				family_q <= cfg_data;
			end
			phase_q  <= phase_d;
			cursor_q <= cursor_d;
			count_q  <= count_d;
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			failed_s1 <= s_tdata[0];
			rom_s1    <= s_tdata[64:1];
			lo_s1     <= s_tdata[72:65];
			hi_s1     <= s_tdata[80:73];
			last_s1   <= s_tlast;
		end
		if (step) begin
			act_s2    <= act_c;
			idx_s2    <= idx_c;
			rom_s2    <= rom_c;
			lo_s2     <= lo_c;
			hi_s2     <= hi_c;
			fail_s2   <= fail_c;
			listed_s2 <= count_ext[LISTED_W-1:0];
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = act_s2;
	assign m_tdata  = {listed_s2, fail_s2, hi_s2, lo_s2, rom_s2, idx_s2};

	// device count never passes the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_C)
		else $error("device count beyond table depth");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= MAX_C)
		else $error("cursor beyond table depth");

	// a search restart always rewinds the cursor
	a_first_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_LIST_FIRST |=> cursor_q == '0 && phase_q == PH_LIST_CHECK)
		else $error("search restart did not rewind cursor");

	// a waiting result transaction holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result transaction changed while waiting");

endmodule

// ===== src/owss_ram.sv =====
// generic single-port-write ram with one registered read port
module owss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
